/* rtl/mtpr_pkg.sv */
// Package with the shared types and constants of the mount table prefix router.
`timescale 1ns / 1ps
package mtpr_pkg;

  // The mount index field is three bits wide, so the table size is fixed here.
  localparam int MOUNT_ENTRIES = 8;

  localparam logic [7:0] SLASH     = 8'h2F;
  localparam logic [6:0] LEN_LIMIT = 7'd64;
  localparam logic [6:0] POS_MAX   = 7'd127;

  typedef enum logic [1:0] {
    OP_ROUTE   = 2'd0,
    OP_MOUNT   = 2'd1,
    OP_UNMOUNT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_EXISTS    = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] path_byte;
    logic       byte_valid;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] mount_index;
    logic [5:0] remainder_offset;
    logic       remainder_is_slash;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic byte_scan;
    logic fin_check;
    logic fin_scan;
    logic report;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic skip;
    logic bad;
  } stat_t;

endpackage

/* rtl/mtpr_ctrl.sv */
// Controller state machine of the mount table prefix router.
`timescale 1ns / 1ps
module mtpr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mtpr_pkg::item_t item,
  input  mtpr_pkg::stat_t stat,
  output mtpr_pkg::cmd_t  cmd,
  output logic           busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_BYTE   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_REPORT = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (start && state == S_IDLE) begin
        last_q <= item.last_byte;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (item.byte_valid) begin
            state_next = S_BYTE;
          end else if (item.last_byte) begin
            state_next = S_CHECK;
          end
        end
      end
      S_BYTE: begin
        cmd.byte_scan = 1'b1;
        if (stat.scan_done) begin
          state_next = last_q ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        cmd.fin_check = 1'b1;
        if (stat.skip) begin
          state_next = S_IDLE;
        end else if (stat.bad) begin
          state_next = S_REPORT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.fin_scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/mtpr_dp.sv */
// Datapath of the mount table prefix router: prefix memory, entry flags and scan logic.
`timescale 1ns / 1ps
module mtpr_dp #(
  parameter int PREFIX_BYTES  = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  mtpr_pkg::item_t   item,
  input  mtpr_pkg::cmd_t    cmd,
  output mtpr_pkg::stat_t   stat,
  output mtpr_pkg::result_t result,
  output logic             done
);

  localparam int MOUNT_ENTRIES = mtpr_pkg::MOUNT_ENTRIES;
  localparam int IW = (MOUNT_ENTRIES > 1) ? $clog2(MOUNT_ENTRIES) : 1;
  localparam int CW = $clog2(MOUNT_ENTRIES + 1);
  localparam int AW = (MOUNT_ENTRIES * PREFIX_BYTES > 1) ?
                      $clog2(MOUNT_ENTRIES * PREFIX_BYTES) : 1;
  localparam int DEPTH = MOUNT_ENTRIES * PREFIX_BYTES;

  logic [7:0] store_mem [DEPTH];
  logic [6:0] len_mem [MOUNT_ENTRIES];

  mtpr_pkg::item_t item_q;
  logic [6:0]   pos;
  logic         first_slash;
  logic [CW-1:0] free_slot;
  logic [MOUNT_ENTRIES-1:0] active, matching, bnd_ok;
  logic [CW-1:0] cnt;
  logic [IW-1:0] rd_idx;
  logic [7:0]   rd_byte;
  logic [6:0]   rd_len;
  logic [6:0]   n_q;
  logic         bad_q;
  logic         found, ex_found;
  logic [IW-1:0] best, ex_idx;
  logic [6:0]   top_len;

  logic [CW-1:0] free_enc;
  logic          issue, proc;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          pos_in_range, absolute;
  logic          hit, exact;
  logic          too_long, slot_free;

  // Lowest inactive entry, or MOUNT_ENTRIES when the table is full.
  always_comb begin
    free_enc = CW'(MOUNT_ENTRIES);
    for (int i = MOUNT_ENTRIES - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_enc = CW'(i);
      end
    end
  end

  assign issue        = (cmd.byte_scan || cmd.fin_scan) && (cnt < CW'(MOUNT_ENTRIES));
  assign proc         = (cmd.byte_scan || cmd.fin_scan) && (cnt != '0);
  assign pos_in_range = (9'(pos) < 9'(PREFIX_BYTES));
  assign rd_addr      = AW'(cnt[IW-1:0]) * AW'(PREFIX_BYTES) +
                        (pos_in_range ? AW'(pos) : '0);
  assign wr_addr      = AW'(free_slot[IW-1:0]) * AW'(PREFIX_BYTES) + AW'(pos);
  assign absolute     = (pos != '0) && first_slash;

  assign stat.scan_done = (cnt == CW'(MOUNT_ENTRIES));
  assign stat.skip      = (item_q.opcode == mtpr_pkg::OP_NONE);
  assign stat.bad       = !absolute;

  // Route hit of the entry being scanned; a one-byte prefix is the root.
  assign hit   = (rd_len == 7'd1) ||
                 (matching[rd_idx] && n_q >= rd_len && (n_q == rd_len || bnd_ok[rd_idx]));
  assign exact = matching[rd_idx] && (rd_len == n_q);

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_byte <= store_mem[rd_addr];
      rd_len  <= len_mem[cnt[IW-1:0]];
      rd_idx  <= cnt[IW-1:0];
    end
    if (cmd.byte_scan && cnt == '0 && free_slot < CW'(MOUNT_ENTRIES) && pos_in_range) begin
      store_mem[wr_addr] <= item_q.path_byte;
    end
    if (cmd.report && !bad_q && item_q.opcode == mtpr_pkg::OP_MOUNT && !too_long &&
        !ex_found && slot_free) begin
      len_mem[free_slot[IW-1:0]] <= n_q;
    end
  end

  assign too_long  = (n_q >= mtpr_pkg::LEN_LIMIT) || (9'(n_q) > 9'(PREFIX_BYTES));
  assign slot_free = (free_slot < CW'(MOUNT_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q      <= '0;
      pos         <= '0;
      first_slash <= 1'b0;
      free_slot   <= '0;
      active      <= '0;
      matching    <= '0;
      bnd_ok      <= '0;
      cnt         <= '0;
      bad_q       <= 1'b0;
      found       <= 1'b0;
      ex_found    <= 1'b0;
      best        <= '0;
      ex_idx      <= '0;
      top_len     <= '0;
      n_q         <= '0;
    end else begin
      if (cmd.load) begin
        item_q <= item;
        cnt    <= '0;
        if (item.byte_valid && pos == '0) begin
          first_slash <= (item.path_byte == mtpr_pkg::SLASH);
          free_slot   <= free_enc;
          matching    <= '1;
          bnd_ok      <= '0;
        end
      end
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.byte_scan && proc && active[rd_idx]) begin
        if (pos < rd_len) begin
          if (rd_byte != item_q.path_byte) begin
            matching[rd_idx] <= 1'b0;
          end
        end else if (pos == rd_len) begin
          bnd_ok[rd_idx] <= (item_q.path_byte == mtpr_pkg::SLASH);
        end
      end
      if (cmd.byte_scan && stat.scan_done && pos != mtpr_pkg::POS_MAX) begin
        pos <= pos + 1'b1;
      end
      if (cmd.fin_check) begin
        n_q         <= pos;
        bad_q       <= !absolute;
        pos         <= '0;
        first_slash <= 1'b0;
        cnt         <= '0;
        found       <= 1'b0;
        ex_found    <= 1'b0;
        best        <= '0;
        top_len     <= '0;
        ex_idx      <= '0;
      end
      if (cmd.fin_scan && proc && active[rd_idx]) begin
        if (hit && (!found || rd_len > top_len)) begin
          found    <= 1'b1;
          best     <= rd_idx;
          top_len  <= rd_len;
        end
        if (exact && !ex_found) begin
          ex_found <= 1'b1;
          ex_idx   <= rd_idx;
        end
      end
      if (cmd.report && !bad_q) begin
        if (item_q.opcode == mtpr_pkg::OP_MOUNT && !too_long && !ex_found && slot_free) begin
          active[free_slot[IW-1:0]] <= 1'b1;
        end
        if (item_q.opcode == mtpr_pkg::OP_UNMOUNT && ex_found) begin
          active[ex_idx] <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    result = '0;
    if (bad_q) begin
      result.status = mtpr_pkg::ST_INVALID;
    end else begin
      unique case (item_q.opcode)
        mtpr_pkg::OP_ROUTE: begin
          if (!found) begin
            result.status = mtpr_pkg::ST_NOT_FOUND;
          end else begin
            result.status      = mtpr_pkg::ST_OK;
            result.mount_index = 3'(best);
            if (top_len != 7'd1) begin
              result.remainder_offset   = 6'(top_len);
              result.remainder_is_slash = (n_q == top_len);
            end
          end
        end
        mtpr_pkg::OP_MOUNT: begin
          if (too_long) begin
            result.status = mtpr_pkg::ST_TOO_LONG;
          end else if (ex_found) begin
            result.status = mtpr_pkg::ST_EXISTS;
          end else if (!slot_free) begin
            result.status = mtpr_pkg::ST_FULL;
          end else begin
            result.status      = mtpr_pkg::ST_OK;
            result.mount_index = 3'(free_slot);
          end
        end
        mtpr_pkg::OP_UNMOUNT: begin
          if (ex_found) begin
            result.status      = mtpr_pkg::ST_OK;
            result.mount_index = 3'(ex_idx);
          end else begin
            result.status = mtpr_pkg::ST_NOT_FOUND;
          end
        end
        default: result = '0;
      endcase
    end
  end

  assign done = cmd.report;

endmodule

/* rtl/mount_table_prefix_router.sv */
// Top level of the mount table prefix router: controller plus datapath.
//
// A path arrives one byte per transaction, raised with start while busy is low.
// Each byte is compared against the entries one at a time through the
// registered read port of the prefix memory. The transaction that ends the
// path then makes a second pass over the entries and presents one result
// with done high for exactly one cycle; the receiver cannot stall it. An
// ending transaction without a byte skips the byte pass. An invalid path
// skips the second pass and goes from the check state straight to the
// report, and opcode 3 ends the path in the check state with no result. A
// transaction with neither a byte nor the end mark is taken without leaving
// the idle state. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module mount_table_prefix_router #(
  parameter int PREFIX_BYTES  = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mtpr_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output mtpr_pkg::result_t result
);

  mtpr_pkg::cmd_t  cmd;
  mtpr_pkg::stat_t stat;

  mtpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mtpr_dp #(
    .PREFIX_BYTES  (PREFIX_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result),
    .done   (done)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result presented while idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result held for more than one cycle");

  a_slash_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.remainder_is_slash |-> result.status == mtpr_pkg::ST_OK)
    else $error("slash remainder flagged on an error result");

endmodule

/* tb/mount_table_prefix_router_tb.sv */
// Self-checking testbench for the mount table prefix router.
`timescale 1ns / 1ps
module mount_table_prefix_router_tb;

  localparam int ENTRIES = mtpr_pkg::MOUNT_ENTRIES;
  localparam int PBYTES  = 64;

  logic              clk;
  logic              rst;
  logic              start;
  mtpr_pkg::item_t   item;
  logic              busy;
  logic              done;
  mtpr_pkg::result_t result;

  mount_table_prefix_router uut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the mount table state.
  logic [7:0] mt_bytes [ENTRIES][PBYTES];
  logic [6:0] mt_len [ENTRIES];
  logic       mt_active [ENTRIES];
  logic       mt_match [ENTRIES];
  logic       mt_bound [ENTRIES];
  logic [6:0] path_pos;
  logic       path_abs;
  int         slot_free;

  mtpr_pkg::result_t status_queue [$];
  int      fail_count;
  bit      gaps_on;
  // Paths sent for mounting, so stimulus can unmount and route into them.
  string   known_paths [$];

  function automatic bit root_entry(int i);
    return mt_len[i] == 7'd1 && mt_bytes[i][0] == mtpr_pkg::SLASH;
  endfunction

  function automatic mtpr_pkg::result_t mk(mtpr_pkg::status_t s, int idx, int off, bit sl);
    mtpr_pkg::result_t r;
    r.status = s;
    r.mount_index = idx[2:0];
    r.remainder_offset = off[5:0];
    r.remainder_is_slash = sl;
    return r;
  endfunction

  task automatic absorb_byte(logic [7:0] b);
    int p;
    p = path_pos;
    if (p == 0) begin
      path_abs = (b == mtpr_pkg::SLASH);
      slot_free = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) begin
        mt_match[i] = 1'b1;
        mt_bound[i] = 1'b0;
        if (!mt_active[i] && slot_free == ENTRIES) slot_free = i;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (mt_active[i]) begin
        if (p < mt_len[i] && p < PBYTES) begin
          if (mt_bytes[i][p] != b) mt_match[i] = 1'b0;
        end else if (p == mt_len[i]) begin
          mt_bound[i] = (b == mtpr_pkg::SLASH);
        end
      end
    end
    if (slot_free < ENTRIES && p < PBYTES) mt_bytes[slot_free][p] = b;
    if (p < mtpr_pkg::POS_MAX) path_pos = 7'(p + 1);
  endtask

  task automatic predict_status(mtpr_pkg::item_t it);
    int n, best, top_len;
    bit found, hit;
    if (it.byte_valid) absorb_byte(it.path_byte);
    if (it.last_byte) begin
      n = path_pos;
      hit = n > 0 && path_abs;
      path_pos = '0;
      path_abs = 1'b0;
      if (mtpr_pkg::opcode_t'(it.opcode) == mtpr_pkg::OP_NONE) return;
      if (!hit) begin
        status_queue.push_back(mk(mtpr_pkg::ST_INVALID, 0, 0, 0));
        return;
      end
      case (mtpr_pkg::opcode_t'(it.opcode))
        mtpr_pkg::OP_ROUTE: begin
          found = 0;
          best = 0;
          top_len = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (mt_active[i] && mt_len[i] != 0 && mt_len[i] <= mtpr_pkg::LEN_LIMIT) begin
              if (root_entry(i)) hit = 1;
              else hit = mt_match[i] && n >= mt_len[i] && (n == mt_len[i] || mt_bound[i]);
              if (hit && (!found || mt_len[i] > top_len)) begin
                found = 1;
                best = i;
                top_len = mt_len[i];
              end
            end
          end
          if (!found) status_queue.push_back(mk(mtpr_pkg::ST_NOT_FOUND, 0, 0, 0));
          else if (root_entry(best)) status_queue.push_back(mk(mtpr_pkg::ST_OK, best, 0, 0));
          else status_queue.push_back(mk(mtpr_pkg::ST_OK, best, top_len, n == top_len));
        end
        mtpr_pkg::OP_MOUNT: begin
          if (n >= mtpr_pkg::LEN_LIMIT || n > PBYTES) begin
            status_queue.push_back(mk(mtpr_pkg::ST_TOO_LONG, 0, 0, 0));
            return;
          end
          for (int i = 0; i < ENTRIES; i++)
            if (mt_active[i] && mt_match[i] && mt_len[i] == n) begin
              status_queue.push_back(mk(mtpr_pkg::ST_EXISTS, 0, 0, 0));
              return;
            end
          if (slot_free >= ENTRIES) begin
            status_queue.push_back(mk(mtpr_pkg::ST_FULL, 0, 0, 0));
            return;
          end
          mt_len[slot_free] = n[6:0];
          mt_active[slot_free] = 1'b1;
          status_queue.push_back(mk(mtpr_pkg::ST_OK, slot_free, 0, 0));
        end
        default: begin
          for (int i = 0; i < ENTRIES; i++)
            if (mt_active[i] && mt_match[i] && mt_len[i] == n) begin
              mt_active[i] = 1'b0;
              status_queue.push_back(mk(mtpr_pkg::ST_OK, i, 0, 0));
              return;
            end
          status_queue.push_back(mk(mtpr_pkg::ST_NOT_FOUND, 0, 0, 0));
        end
      endcase
    end
  endtask

  // Sends one transaction and records its expected status. Start stays high
  // after acceptance so the next transaction can follow without a gap.
  task automatic send_item(mtpr_pkg::opcode_t op, logic [7:0] b, bit vld, bit lst);
    mtpr_pkg::item_t it;
    int gap;
    it.opcode = op;
    it.path_byte = b;
    it.byte_valid = vld;
    it.last_byte = lst;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      item <= mtpr_pkg::item_t'(12'($urandom) & 12'hFFC);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_status(it);
  endtask

  task automatic send_path(mtpr_pkg::opcode_t op, string s);
    if (s.len() == 0) begin
      send_item(op, 8'($urandom), 1'b0, 1'b1);
      return;
    end
    for (int k = 0; k < s.len(); k++) begin
      // Occasional byteless filler items in the middle of a path.
      if (k > 0 && $urandom_range(0, 15) == 0)
        send_item(mtpr_pkg::opcode_t'($urandom_range(0, 3)), 8'($urandom), 1'b0, 1'b0);
      send_item(op, s[k], 1'b1, k == s.len() - 1);
    end
  endtask

  function automatic string rand_path(int max_seg);
    string s;
    int nseg;
    byte alpha [4] = '{"a", "b", "c", "/"};
    s = "";
    nseg = $urandom_range(1, max_seg);
    for (int k = 0; k < nseg; k++) begin
      s = {s, "/"};
      repeat ($urandom_range(0, 2)) s = {s, string'(alpha[$urandom_range(0, 2)])};
    end
    if ($urandom_range(0, 7) == 0) s = {s, "/"};
    return s;
  endfunction

  task automatic drain_results();
    start <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  always @(posedge clk) begin
    mtpr_pkg::result_t want;
    if (!rst && done) begin
      if (status_queue.size() == 0) begin
        $error("status with no transaction pending: %p", result);
        fail_count++;
      end else begin
        want = status_queue.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          fail_count++;
        end
        if (result.mount_index !== want.mount_index) begin
          $error("mount_index: expected %0d, got %0d", want.mount_index, result.mount_index);
          fail_count++;
        end
        if (result.remainder_offset !== want.remainder_offset) begin
          $error("remainder_offset: expected %0d, got %0d",
                 want.remainder_offset, result.remainder_offset);
          fail_count++;
        end
        if (result.remainder_is_slash !== want.remainder_is_slash) begin
          $error("remainder_is_slash: expected %0d, got %0d",
                 want.remainder_is_slash, result.remainder_is_slash);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    string longp;
    send_path(mtpr_pkg::OP_ROUTE, "/x");
    send_path(mtpr_pkg::OP_MOUNT, "");
    send_path(mtpr_pkg::OP_UNMOUNT, "rel");
    send_path(mtpr_pkg::OP_MOUNT, "/");
    send_path(mtpr_pkg::OP_MOUNT, "/usr");
    send_path(mtpr_pkg::OP_MOUNT, "/usr/lib");
    send_path(mtpr_pkg::OP_MOUNT, "/usr");
    send_path(mtpr_pkg::OP_ROUTE, "/usr/lib/x");
    send_path(mtpr_pkg::OP_ROUTE, "/usr");
    send_path(mtpr_pkg::OP_ROUTE, "/usrx");
    send_path(mtpr_pkg::OP_ROUTE, "/");
    send_path(mtpr_pkg::OP_NONE, "/usr");
    send_item(mtpr_pkg::OP_ROUTE, 8'hFF, 1'b1, 1'b0);
    send_item(mtpr_pkg::OP_ROUTE, 8'h00, 1'b0, 1'b1);
    longp = "/";
    repeat (62) longp = {longp, "a"};
    send_path(mtpr_pkg::OP_MOUNT, longp);
    send_path(mtpr_pkg::OP_ROUTE, longp);
    longp = {longp, "b"};
    send_path(mtpr_pkg::OP_MOUNT, longp);
    repeat (80) longp = {longp, "c"};
    send_path(mtpr_pkg::OP_ROUTE, longp);
    send_path(mtpr_pkg::OP_UNMOUNT, "/usr");
    send_path(mtpr_pkg::OP_UNMOUNT, "/usr");
    for (int i = 0; i < 7; i++) send_path(mtpr_pkg::OP_MOUNT, $sformatf("/m%0d", i));
    send_path(mtpr_pkg::OP_ROUTE, "/m3/q");
  endtask

  task automatic test_random(int total);
    int sent;
    string p;
    sent = 0;
    while (sent < total) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          p = rand_path(3);
          send_path(mtpr_pkg::OP_MOUNT, p);
          known_paths.push_back(p);
        end
        2: begin
          if (known_paths.size() != 0)
            p = known_paths[$urandom_range(0, known_paths.size() - 1)];
          else p = rand_path(2);
          send_path(mtpr_pkg::OP_UNMOUNT, p);
        end
        3: begin
          // Noise: arbitrary bytes and opcodes.
          p = "";
          repeat ($urandom_range(1, 4)) begin
            send_item(mtpr_pkg::opcode_t'($urandom_range(0, 3)), 8'($urandom),
                      1'($urandom), 1'($urandom));
            sent++;
          end
        end
        default: begin
          if (known_paths.size() != 0 && $urandom_range(0, 1))
            p = {known_paths[$urandom_range(0, known_paths.size() - 1)], rand_path(2)};
          else p = rand_path(4);
          send_path(mtpr_pkg::OP_ROUTE, p);
        end
      endcase
      sent += p.len();
      if (known_paths.size() > 20) void'(known_paths.pop_front());
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    fail_count = 0;
    gaps_on = 1;
    path_pos = '0;
    path_abs = 1'b0;
    slot_free = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      mt_len[i] = '0;
      mt_active[i] = 1'b0;
      mt_match[i] = 1'b0;
      mt_bound[i] = 1'b0;
      for (int k = 0; k < PBYTES; k++) mt_bytes[i][k] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    // Hold the sender off until every status is back.
    drain_results();
    test_random(600);
    gaps_on = 0;
    test_random(200);
    drain_results();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/mtpr_pkg.sv
rtl/mtpr_ctrl.sv
rtl/mtpr_dp.sv
rtl/mount_table_prefix_router.sv
tb/mount_table_prefix_router_tb.sv
